// ----- sv/wpm_pkg.sv -----
// Package with the transaction types, function codes and character helpers of the glob matcher.
package wpm_pkg;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_SOURCE = 2'd2,
    FUNC_FINISH = 2'd3
  } func_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_item_t;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;
  localparam logic [7:0] UPPER_A   = 8'h41;
  localparam logic [7:0] UPPER_Z   = 8'h5A;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  // ASCII lower-casing: only A to Z change.
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) begin
      r = c | CASE_BIT;
    end
    return r;
  endfunction

endpackage

// ----- sv/wildcard_pattern_match_core.sv -----
// Streaming glob matcher with '*' and '?' wildcards, one transaction per cycle while the input is not stalled.
// Result path: an accepted finish transaction enters the input register, then the processing pass loads
//   the result register once any earlier result has left it.
// Throughput: one input transaction per cycle, set by the single processing pass that updates
//   the active-position vector for all pattern positions at once; a finish stalls only while
//   an earlier result is still waiting in the result register.
// Reset: pattern length, overflow flag and fold_case clear, only the start position is active;
//   the pattern store is not cleared, since entries at or above the length are never used.
module wildcard_pattern_match_core #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel (fold_case).
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i,
  // Input transaction channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wpm_pkg::in_item_t   in_data_i,
  // Result transaction channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wpm_pkg::out_item_t  out_data_o
);

  // LW holds a length from 0 to MAX_PATTERN, IW indexes one store entry.
  localparam int unsigned LW   = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LVLS = $clog2(MAX_PATTERN + 1);
  localparam int unsigned NP   = MAX_PATTERN + 1;

  // Configuration register. Writes must arrive only while the block is idle (not enforced); always ready.
  logic fold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= 1'b0;
    end else if (cfg_valid_i) begin
      fold_q <= cfg_data_i;
    end
  end

  // Input register. A transaction moves on whenever the processing pass can take it.
  logic              s1_valid_q;
  wpm_pkg::in_item_t s1_item_q;
  logic              s1_fire;
  logic              out_valid_q;
  wpm_pkg::out_item_t out_q;

  // Only a finish produces a result, so only a finish has to wait for the result register.
  assign s1_fire    = s1_valid_q &&
                      ((s1_item_q.func != wpm_pkg::FUNC_FINISH) || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_data_i;
    end
  end

  // Job state. The pattern store is a plain register row because every position compares
  // its own character against the source character in the same cycle.
  logic [7:0]    store_q [MAX_PATTERN];
  logic [LW-1:0] len_q, len_d;
  logic [NP-1:0] act_q, act_d;
  logic          ovf_q, ovf_d;

  // Per-position decode of the current pattern, masked to the stored length.
  logic [MAX_PATTERN-1:0] pos_used;
  logic [MAX_PATTERN-1:0] is_star;
  logic [MAX_PATTERN-1:0] takes_char;
  logic [7:0]             sym_lower;

  always_comb begin
    sym_lower = wpm_pkg::to_lower(s1_item_q.symbol);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pos_used[i]   = len_q > LW'(i);
      is_star[i]    = pos_used[i] && (store_q[i] == wpm_pkg::STAR_CHAR);
      takes_char[i] = pos_used[i] && !is_star[i] &&
                      ((store_q[i] == wpm_pkg::ANY_CHAR) ||
                       (store_q[i] == s1_item_q.symbol) ||
                       (fold_q && (wpm_pkg::to_lower(store_q[i]) == sym_lower)));
    end
  end

  // Star closure: an active star activates the next position, and runs of stars chain.
  // This is a prefix OR-AND chain, built as a log-depth parallel prefix network.
  logic [NP-1:0] clo_g, clo_p, clo_gn, clo_pn;

  always_comb begin
    clo_g = act_q;
    clo_p = '0;
    for (int i = 1; i < NP; i++) begin
      clo_p[i] = is_star[i-1];
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < NP; i++) begin
        if (i >= (1 << l)) begin
          clo_gn[i] = clo_g[i] | (clo_p[i] & clo_g[i - (1 << l)]);
          clo_pn[i] = clo_p[i] & clo_p[i - (1 << l)];
        end else begin
          clo_gn[i] = clo_g[i];
          clo_pn[i] = clo_p[i];
        end
      end
      clo_g = clo_gn;
      clo_p = clo_pn;
    end
  end

  // Step of the active set for one source character: a star keeps its position active,
  // a matching character or '?' advances by one.
  logic [NP-1:0] act_step;

  always_comb begin
    act_step = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      act_step[i]   = act_step[i]   | (clo_g[i] & is_star[i]);
      act_step[i+1] = act_step[i+1] | (clo_g[i] & takes_char[i]);
    end
  end

  // Next-state selection by function code.
  logic store_we;

  always_comb begin
    len_d    = len_q;
    act_d    = act_q;
    ovf_d    = ovf_q;
    store_we = 1'b0;
    case (s1_item_q.func)
      wpm_pkg::FUNC_START: begin
        len_d = '0;
        act_d = NP'(1);
        ovf_d = 1'b0;
      end
      wpm_pkg::FUNC_APPEND: begin
        if (len_q < LW'(MAX_PATTERN)) begin
          store_we = 1'b1;
          len_d    = len_q + LW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      wpm_pkg::FUNC_SOURCE: begin
        act_d = act_step;
      end
      wpm_pkg::FUNC_FINISH: begin
        // The result reads the closed set; the stored set is closed again before any use.
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      act_q <= NP'(1);
      ovf_q <= 1'b0;
    end else if (s1_fire) begin
      len_q <= len_d;
      act_q <= act_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && store_we) begin
      store_q[len_q[IW-1:0]] <= s1_item_q.symbol;
    end
  end

  // Result register. The whole source matches when no overflow occurred and the end position is active after closure.
  logic result_load;

  assign result_load = s1_fire && (s1_item_q.func == wpm_pkg::FUNC_FINISH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_load) begin
      out_q.matched          <= !ovf_q && clo_g[len_q];
      out_q.pattern_overflow <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Positions above the stored length can never be active.
  logic [NP-1:0] len_mask;

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      len_mask[i] = LW'(i) <= len_q;
    end
  end

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_PATTERN))
    else $error("pattern length exceeds the store");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (len_q == LW'(MAX_PATTERN)))
    else $error("overflow flagged with room left in the store");

  a_act_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q & ~len_mask) == '0)
    else $error("active position beyond the pattern end");

  a_ovf_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.matched && out_q.pattern_overflow))
    else $error("match reported together with overflow");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && (s1_item_q.func == wpm_pkg::FUNC_FINISH) && out_valid_q))
    else $error("input stalled without a blocked finish");

  a_finish_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_load |=> out_valid_o)
    else $error("finish transaction produced no result");

endmodule
